/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication check, sampled on the rising clock, off during reset
`define CHK_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// a condition that must never be seen
`define CHK_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

/* rtl/core/chg_pkg.sv */
// ----------------------------------------------------------------------------
// chg_pkg
// shared constants, types and codes of the convex hull block
// ----------------------------------------------------------------------------
package chg_pkg;

    localparam int MAX_POINTS = 32;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int DIST_W     = PROD_W;
    localparam int ODIST_W    = 2 * COORD_BITS + 1;
    localparam int IN_W       = 2 * COORD_BITS;
    localparam int OUT_FIELDS = 6 * COORD_BITS + ODIST_W;
    localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8;

    // one point, x in the low bits
    typedef struct packed {
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_pt;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_PIV_RD,
        ST_PIV_CMP,
        ST_SORT_INIT,
        ST_SORT_CHK,
        ST_SORT_KEY,
        ST_SORT_CRD,
        ST_SORT_ITEM,
        ST_SORT_GEO,
        ST_SORT_WAIT,
        ST_SORT_PUT,
        ST_SCAN_INIT,
        ST_SCAN_CHK,
        ST_SCAN_C,
        ST_SCAN_GEO,
        ST_SCAN_WAIT,
        ST_SCAN_POPA,
        ST_SCAN_PUSH,
        ST_FAR_INIT,
        ST_FAR_ICHK,
        ST_FAR_I,
        ST_FAR_JRD,
        ST_FAR_J,
        ST_FAR_GEO,
        ST_FAR_WAIT,
        ST_FAR_INEXT,
        ST_OUT_INIT,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PIV_CMP,
        OP_SORT_INIT,
        OP_SORT_SKIP,
        OP_SORT_KEY,
        OP_SORT_CRD,
        OP_SORT_ITEM,
        OP_SORT_GEO,
        OP_SORT_SHIFT,
        OP_SORT_PUT,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_C,
        OP_SCAN_GEO,
        OP_SCAN_POP,
        OP_SCAN_POPA,
        OP_SCAN_PUSH,
        OP_FAR_INIT,
        OP_FAR_IRD,
        OP_FAR_I,
        OP_FAR_JRD,
        OP_FAR_J,
        OP_FAR_GEO,
        OP_FAR_UPD,
        OP_FAR_INEXT,
        OP_OUT_INIT,
        OP_OUT_RD,
        OP_OUT_LD,
        OP_OUT_NEXT,
        OP_OUT_DONE
    } t_op;

    // status from datapath to controller
    typedef struct packed {
        logic acc;
        logic acc_last;
        logic i_last_n;
        logic i_eq_n;
        logic i_eq_pi;
        logic m_zero;
        logic j_one;
        logic geo_done;
        logic prec;
        logic right;
        logic i_eq_m;
        logic top_gt2;
        logic i1_ge_top;
        logic j1_eq_top;
        logic i1_eq_top;
        logic taken;
    } t_sts;

endpackage

/* rtl/core/chg_geo.sv */
// ----------------------------------------------------------------------------
// chg_geo
// three-stage cross product and squared length unit
// ----------------------------------------------------------------------------
module chg_geo (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  chg_pkg::t_pt                         i_a,
    input  chg_pkg::t_pt                         i_b,
    input  chg_pkg::t_pt                         i_c,
    input  chg_pkg::t_pt                         i_d,
    output logic                                 o_done,
    output logic signed [chg_pkg::CROSS_W-1:0]   o_cross,
    output logic        [chg_pkg::DIST_W-1:0]    o_du,
    output logic        [chg_pkg::DIST_W-1:0]    o_dv
);

    logic [2:0] r_v;
    logic signed [chg_pkg::DIFF_W-1:0] r_ux, r_uy, r_vx, r_vy;
    logic signed [chg_pkg::PROD_W-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_start};
        end
    end

    // u = b - a, v = c - d
    always_ff @(posedge i_clk) begin
        r_ux <= chg_pkg::DIFF_W'(i_b.x) - chg_pkg::DIFF_W'(i_a.x);
        r_uy <= chg_pkg::DIFF_W'(i_b.y) - chg_pkg::DIFF_W'(i_a.y);
        r_vx <= chg_pkg::DIFF_W'(i_c.x) - chg_pkg::DIFF_W'(i_d.x);
        r_vy <= chg_pkg::DIFF_W'(i_c.y) - chg_pkg::DIFF_W'(i_d.y);
    end

    // products
    always_ff @(posedge i_clk) begin
        r_p0 <= r_ux * r_vy;
        r_p1 <= r_uy * r_vx;
        r_p2 <= r_ux * r_ux;
        r_p3 <= r_uy * r_uy;
        r_p4 <= r_vx * r_vx;
        r_p5 <= r_vy * r_vy;
    end

    // cross product and squared lengths
    always_ff @(posedge i_clk) begin
        o_cross <= chg_pkg::CROSS_W'(r_p0) - chg_pkg::CROSS_W'(r_p1);
        o_du    <= chg_pkg::DIST_W'(r_p2) + chg_pkg::DIST_W'(r_p3);
        o_dv    <= chg_pkg::DIST_W'(r_p4) + chg_pkg::DIST_W'(r_p5);
    end

    assign o_done = r_v[2];

endmodule

/* rtl/core/chg_dp.sv */
// ----------------------------------------------------------------------------
// chg_dp
// point, sort and hull memories, counters, geometry unit and output register
// ----------------------------------------------------------------------------
module chg_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  chg_pkg::t_op                  i_op,
    output chg_pkg::t_sts                 o_sts,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [chg_pkg::IN_W-1:0]      s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [chg_pkg::OUT_W-1:0]     m_axis_tdata,
    output logic                          m_axis_tlast
);

    localparam int PAD_W = chg_pkg::OUT_W - chg_pkg::OUT_FIELDS;

    chg_pkg::t_pt pmem [chg_pkg::MAX_POINTS];
    chg_pkg::t_pt sbuf [chg_pkg::MAX_POINTS];
    chg_pkg::t_pt stk  [chg_pkg::MAX_POINTS];

    logic [chg_pkg::CNT_W-1:0] r_cnt, r_i, r_j, r_m, r_top;
    logic [chg_pkg::IDX_W-1:0] r_pi;
    chg_pkg::t_pt r_piv, r_key, r_item, r_a, r_b, r_c, r_pa, r_pb, r_fa, r_fb;
    chg_pkg::t_pt r_rd_p, r_rd_s, r_rd_k;
    logic [chg_pkg::DIST_W-1:0] r_best;
    logic [chg_pkg::OUT_W-1:0]  r_odata;
    logic r_olast, r_ovalid;

    logic w_acc, w_full, w_lower, w_geo_start, w_geo_done;
    logic [chg_pkg::CNT_W-1:0] w_jm1, w_topm3;
    logic [chg_pkg::IDX_W-1:0] w_s_raddr, w_k_raddr, w_k_waddr;
    logic w_k_we, w_s_we;
    chg_pkg::t_pt w_k_wdata, w_s_wdata, w_ga, w_gb, w_gc, w_gd;
    logic signed [chg_pkg::CROSS_W-1:0] w_cross;
    logic [chg_pkg::DIST_W-1:0] w_du, w_dv;

    assign s_axis_tready = (i_op == chg_pkg::OP_LOAD);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_cnt == chg_pkg::CNT_W'(chg_pkg::MAX_POINTS));
    assign w_jm1         = r_j - chg_pkg::CNT_W'(1);
    assign w_topm3       = r_top - chg_pkg::CNT_W'(3);

    // point store
    always_ff @(posedge i_clk) begin
        if (w_acc && !w_full) begin
            pmem[r_cnt[chg_pkg::IDX_W-1:0]] <= s_axis_tdata;
        end
        r_rd_p <= pmem[r_i[chg_pkg::IDX_W-1:0]];
    end

    // sort buffer
    assign w_s_raddr = (i_op == chg_pkg::OP_SORT_CRD) ? w_jm1[chg_pkg::IDX_W-1:0]
                                                      : r_i[chg_pkg::IDX_W-1:0];
    assign w_s_we    = (i_op == chg_pkg::OP_SORT_SHIFT) || (i_op == chg_pkg::OP_SORT_PUT);
    assign w_s_wdata = (i_op == chg_pkg::OP_SORT_SHIFT) ? r_item : r_key;

    always_ff @(posedge i_clk) begin
        if (w_s_we) begin
            sbuf[r_j[chg_pkg::IDX_W-1:0]] <= w_s_wdata;
        end
        r_rd_s <= sbuf[w_s_raddr];
    end

    // hull stack
    always_comb begin
        case (i_op)
            chg_pkg::OP_SCAN_POP: w_k_raddr = w_topm3[chg_pkg::IDX_W-1:0];
            chg_pkg::OP_FAR_JRD:  w_k_raddr = r_j[chg_pkg::IDX_W-1:0];
            default:              w_k_raddr = r_i[chg_pkg::IDX_W-1:0];
        endcase
    end
    assign w_k_we    = (i_op == chg_pkg::OP_SCAN_INIT) || (i_op == chg_pkg::OP_SCAN_PUSH);
    assign w_k_waddr = (i_op == chg_pkg::OP_SCAN_INIT) ? '0 : r_top[chg_pkg::IDX_W-1:0];
    assign w_k_wdata = (i_op == chg_pkg::OP_SCAN_INIT) ? r_piv : r_c;

    always_ff @(posedge i_clk) begin
        if (w_k_we) begin
            stk[w_k_waddr] <= w_k_wdata;
        end
        r_rd_k <= stk[w_k_raddr];
    end

    // geometry operand select
    always_comb begin
        case (i_op)
            chg_pkg::OP_SORT_GEO: begin
                w_ga = r_piv; w_gb = r_key; w_gc = r_item; w_gd = r_piv;
            end
            chg_pkg::OP_SCAN_GEO: begin
                w_ga = r_a; w_gb = r_b; w_gc = r_c; w_gd = r_b;
            end
            default: begin
                w_ga = r_pa; w_gb = r_pb; w_gc = r_pa; w_gd = r_pa;
            end
        endcase
    end
    assign w_geo_start = (i_op == chg_pkg::OP_SORT_GEO) || (i_op == chg_pkg::OP_SCAN_GEO)
                      || (i_op == chg_pkg::OP_FAR_GEO);

    chg_geo u_geo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_geo_start),
        .i_a     (w_ga),
        .i_b     (w_gb),
        .i_c     (w_gc),
        .i_d     (w_gd),
        .o_done  (w_geo_done),
        .o_cross (w_cross),
        .o_du    (w_du),
        .o_dv    (w_dv)
    );

    // lowest point, smaller x on a tie
    assign w_lower = ($signed(r_rd_p.y) < $signed(r_piv.y))
                  || ((r_rd_p.y == r_piv.y) && ($signed(r_rd_p.x) < $signed(r_piv.x)));

    // counters and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_m      <= '0;
            r_top    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (i_op)
                chg_pkg::OP_LOAD: begin
                    r_i <= '0;
                    if (w_acc && !w_full) begin
                        r_cnt <= r_cnt + chg_pkg::CNT_W'(1);
                    end
                end
                chg_pkg::OP_PIV_CMP:    r_i <= r_i + chg_pkg::CNT_W'(1);
                chg_pkg::OP_SORT_INIT: begin
                    r_i <= '0;
                    r_m <= '0;
                end
                chg_pkg::OP_SORT_SKIP:  r_i <= r_i + chg_pkg::CNT_W'(1);
                chg_pkg::OP_SORT_KEY:   r_j <= r_m;
                chg_pkg::OP_SORT_SHIFT: r_j <= w_jm1;
                chg_pkg::OP_SORT_PUT: begin
                    r_m <= r_m + chg_pkg::CNT_W'(1);
                    r_i <= r_i + chg_pkg::CNT_W'(1);
                end
                chg_pkg::OP_SCAN_INIT: begin
                    r_i   <= '0;
                    r_top <= chg_pkg::CNT_W'(1);
                end
                chg_pkg::OP_SCAN_POP:   r_top <= r_top - chg_pkg::CNT_W'(1);
                chg_pkg::OP_SCAN_PUSH: begin
                    r_top <= r_top + chg_pkg::CNT_W'(1);
                    r_i   <= r_i + chg_pkg::CNT_W'(1);
                end
                chg_pkg::OP_FAR_INIT:   r_i <= '0;
                chg_pkg::OP_FAR_I:      r_j <= r_i + chg_pkg::CNT_W'(1);
                chg_pkg::OP_FAR_UPD:    r_j <= r_j + chg_pkg::CNT_W'(1);
                chg_pkg::OP_FAR_INEXT:  r_i <= r_i + chg_pkg::CNT_W'(1);
                chg_pkg::OP_OUT_INIT:   r_i <= '0;
                chg_pkg::OP_OUT_LD:     r_ovalid <= 1'b1;
                chg_pkg::OP_OUT_NEXT:   r_i <= r_i + chg_pkg::CNT_W'(1);
                chg_pkg::OP_OUT_DONE:   r_cnt <= '0;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            chg_pkg::OP_PIV_CMP: begin
                if (r_i == '0 || w_lower) begin
                    r_piv <= r_rd_p;
                    r_pi  <= r_i[chg_pkg::IDX_W-1:0];
                end
            end
            chg_pkg::OP_SORT_KEY:  r_key  <= r_rd_p;
            chg_pkg::OP_SORT_ITEM: r_item <= r_rd_s;
            chg_pkg::OP_SCAN_INIT: r_b    <= r_piv;
            chg_pkg::OP_SCAN_C:    r_c    <= r_rd_s;
            chg_pkg::OP_SCAN_POP:  r_b    <= r_a;
            chg_pkg::OP_SCAN_POPA: r_a    <= r_rd_k;
            chg_pkg::OP_SCAN_PUSH: begin
                r_a <= r_b;
                r_b <= r_c;
            end
            chg_pkg::OP_FAR_INIT: begin
                r_best <= '0;
                r_fa   <= r_piv;
                r_fb   <= r_piv;
            end
            chg_pkg::OP_FAR_I:     r_pa <= r_rd_k;
            chg_pkg::OP_FAR_J:     r_pb <= r_rd_k;
            chg_pkg::OP_FAR_UPD: begin
                if (w_du > r_best) begin
                    r_best <= w_du;
                    r_fa   <= r_pa;
                    r_fb   <= r_pb;
                end
            end
            chg_pkg::OP_OUT_LD: begin
                r_olast <= o_sts.i1_eq_top;
                if (o_sts.i1_eq_top) begin
                    r_odata <= {PAD_W'(0), r_best[chg_pkg::ODIST_W-1:0], r_fb, r_fa, r_rd_k};
                end else begin
                    r_odata <= {(chg_pkg::OUT_W - chg_pkg::IN_W)'(0), r_rd_k};
                end
            end
            default: ;
        endcase
    end

    // status
    always_comb begin
        o_sts.acc       = w_acc;
        o_sts.acc_last  = w_acc && s_axis_tlast;
        o_sts.i_last_n  = (r_i + chg_pkg::CNT_W'(1)) == r_cnt;
        o_sts.i_eq_n    = (r_i == r_cnt);
        o_sts.i_eq_pi   = (r_i == {1'b0, r_pi});
        o_sts.m_zero    = (r_m == '0);
        o_sts.j_one     = (r_j == chg_pkg::CNT_W'(1));
        o_sts.geo_done  = w_geo_done;
        o_sts.prec      = (w_cross > 0) || ((w_cross == '0) && (w_du < w_dv));
        o_sts.right     = (w_cross < 0);
        o_sts.i_eq_m    = (r_i == r_m);
        o_sts.top_gt2   = (r_top > chg_pkg::CNT_W'(2));
        o_sts.i1_ge_top = (r_i + chg_pkg::CNT_W'(1)) >= r_top;
        o_sts.j1_eq_top = (r_j + chg_pkg::CNT_W'(1)) == r_top;
        o_sts.i1_eq_top = (r_i + chg_pkg::CNT_W'(1)) == r_top;
        o_sts.taken     = m_axis_tvalid && m_axis_tready;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

endmodule

/* rtl/core/chg_ctrl.sv */
// ----------------------------------------------------------------------------
// chg_ctrl
// sequencer for load, pivot search, insertion sort, scan, pair search, output
// ----------------------------------------------------------------------------
module chg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  chg_pkg::t_sts  i_sts,
    output chg_pkg::t_op   o_op
);

    chg_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chg_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            chg_pkg::ST_LOAD:      if (i_sts.acc_last) n_state = chg_pkg::ST_PIV_RD;
            chg_pkg::ST_PIV_RD:    n_state = chg_pkg::ST_PIV_CMP;
            chg_pkg::ST_PIV_CMP:   n_state = i_sts.i_last_n ? chg_pkg::ST_SORT_INIT
                                                            : chg_pkg::ST_PIV_RD;
            chg_pkg::ST_SORT_INIT: n_state = chg_pkg::ST_SORT_CHK;
            chg_pkg::ST_SORT_CHK: begin
                if (i_sts.i_eq_n) begin
                    n_state = chg_pkg::ST_SCAN_INIT;
                end else if (!i_sts.i_eq_pi) begin
                    n_state = chg_pkg::ST_SORT_KEY;
                end
            end
            chg_pkg::ST_SORT_KEY:  n_state = i_sts.m_zero ? chg_pkg::ST_SORT_PUT
                                                          : chg_pkg::ST_SORT_CRD;
            chg_pkg::ST_SORT_CRD:  n_state = chg_pkg::ST_SORT_ITEM;
            chg_pkg::ST_SORT_ITEM: n_state = chg_pkg::ST_SORT_GEO;
            chg_pkg::ST_SORT_GEO:  n_state = chg_pkg::ST_SORT_WAIT;
            chg_pkg::ST_SORT_WAIT: begin
                if (i_sts.geo_done) begin
                    if (i_sts.prec && !i_sts.j_one) begin
                        n_state = chg_pkg::ST_SORT_CRD;
                    end else begin
                        n_state = chg_pkg::ST_SORT_PUT;
                    end
                end
            end
            chg_pkg::ST_SORT_PUT:  n_state = chg_pkg::ST_SORT_CHK;
            chg_pkg::ST_SCAN_INIT: n_state = chg_pkg::ST_SCAN_CHK;
            chg_pkg::ST_SCAN_CHK:  n_state = i_sts.i_eq_m ? chg_pkg::ST_FAR_INIT
                                                          : chg_pkg::ST_SCAN_C;
            chg_pkg::ST_SCAN_C,
            chg_pkg::ST_SCAN_POPA: n_state = i_sts.top_gt2 ? chg_pkg::ST_SCAN_GEO
                                                           : chg_pkg::ST_SCAN_PUSH;
            chg_pkg::ST_SCAN_GEO:  n_state = chg_pkg::ST_SCAN_WAIT;
            chg_pkg::ST_SCAN_WAIT: begin
                if (i_sts.geo_done) begin
                    n_state = i_sts.right ? chg_pkg::ST_SCAN_POPA : chg_pkg::ST_SCAN_PUSH;
                end
            end
            chg_pkg::ST_SCAN_PUSH: n_state = chg_pkg::ST_SCAN_CHK;
            chg_pkg::ST_FAR_INIT:  n_state = chg_pkg::ST_FAR_ICHK;
            chg_pkg::ST_FAR_ICHK:  n_state = i_sts.i1_ge_top ? chg_pkg::ST_OUT_INIT
                                                             : chg_pkg::ST_FAR_I;
            chg_pkg::ST_FAR_I:     n_state = chg_pkg::ST_FAR_JRD;
            chg_pkg::ST_FAR_JRD:   n_state = chg_pkg::ST_FAR_J;
            chg_pkg::ST_FAR_J:     n_state = chg_pkg::ST_FAR_GEO;
            chg_pkg::ST_FAR_GEO:   n_state = chg_pkg::ST_FAR_WAIT;
            chg_pkg::ST_FAR_WAIT: begin
                if (i_sts.geo_done) begin
                    n_state = i_sts.j1_eq_top ? chg_pkg::ST_FAR_INEXT : chg_pkg::ST_FAR_JRD;
                end
            end
            chg_pkg::ST_FAR_INEXT: n_state = chg_pkg::ST_FAR_ICHK;
            chg_pkg::ST_OUT_INIT:  n_state = chg_pkg::ST_OUT_RD;
            chg_pkg::ST_OUT_RD:    n_state = chg_pkg::ST_OUT_LD;
            chg_pkg::ST_OUT_LD:    n_state = chg_pkg::ST_OUT_WAIT;
            chg_pkg::ST_OUT_WAIT: begin
                if (i_sts.taken) begin
                    n_state = i_sts.i1_eq_top ? chg_pkg::ST_LOAD : chg_pkg::ST_OUT_RD;
                end
            end
            default:               n_state = chg_pkg::ST_LOAD;
        endcase
    end

    // datapath commands
    always_comb begin
        o_op = chg_pkg::OP_NONE;
        case (r_state)
            chg_pkg::ST_LOAD:      o_op = chg_pkg::OP_LOAD;
            chg_pkg::ST_PIV_CMP:   o_op = chg_pkg::OP_PIV_CMP;
            chg_pkg::ST_SORT_INIT: o_op = chg_pkg::OP_SORT_INIT;
            chg_pkg::ST_SORT_CHK: begin
                if (!i_sts.i_eq_n && i_sts.i_eq_pi) o_op = chg_pkg::OP_SORT_SKIP;
            end
            chg_pkg::ST_SORT_KEY:  o_op = chg_pkg::OP_SORT_KEY;
            chg_pkg::ST_SORT_CRD:  o_op = chg_pkg::OP_SORT_CRD;
            chg_pkg::ST_SORT_ITEM: o_op = chg_pkg::OP_SORT_ITEM;
            chg_pkg::ST_SORT_GEO:  o_op = chg_pkg::OP_SORT_GEO;
            chg_pkg::ST_SORT_WAIT: begin
                if (i_sts.geo_done && i_sts.prec) o_op = chg_pkg::OP_SORT_SHIFT;
            end
            chg_pkg::ST_SORT_PUT:  o_op = chg_pkg::OP_SORT_PUT;
            chg_pkg::ST_SCAN_INIT: o_op = chg_pkg::OP_SCAN_INIT;
            chg_pkg::ST_SCAN_CHK:  o_op = chg_pkg::OP_SCAN_RD;
            chg_pkg::ST_SCAN_C:    o_op = chg_pkg::OP_SCAN_C;
            chg_pkg::ST_SCAN_GEO:  o_op = chg_pkg::OP_SCAN_GEO;
            chg_pkg::ST_SCAN_WAIT: begin
                if (i_sts.geo_done && i_sts.right) o_op = chg_pkg::OP_SCAN_POP;
            end
            chg_pkg::ST_SCAN_POPA: o_op = chg_pkg::OP_SCAN_POPA;
            chg_pkg::ST_SCAN_PUSH: o_op = chg_pkg::OP_SCAN_PUSH;
            chg_pkg::ST_FAR_INIT:  o_op = chg_pkg::OP_FAR_INIT;
            chg_pkg::ST_FAR_ICHK:  o_op = chg_pkg::OP_FAR_IRD;
            chg_pkg::ST_FAR_I:     o_op = chg_pkg::OP_FAR_I;
            chg_pkg::ST_FAR_JRD:   o_op = chg_pkg::OP_FAR_JRD;
            chg_pkg::ST_FAR_J:     o_op = chg_pkg::OP_FAR_J;
            chg_pkg::ST_FAR_GEO:   o_op = chg_pkg::OP_FAR_GEO;
            chg_pkg::ST_FAR_WAIT: begin
                if (i_sts.geo_done) o_op = chg_pkg::OP_FAR_UPD;
            end
            chg_pkg::ST_FAR_INEXT: o_op = chg_pkg::OP_FAR_INEXT;
            chg_pkg::ST_OUT_INIT:  o_op = chg_pkg::OP_OUT_INIT;
            chg_pkg::ST_OUT_RD:    o_op = chg_pkg::OP_OUT_RD;
            chg_pkg::ST_OUT_LD:    o_op = chg_pkg::OP_OUT_LD;
            chg_pkg::ST_OUT_WAIT: begin
                if (i_sts.taken) begin
                    o_op = i_sts.i1_eq_top ? chg_pkg::OP_OUT_DONE : chg_pkg::OP_OUT_NEXT;
                end
            end
            default:               o_op = chg_pkg::OP_NONE;
        endcase
    end

endmodule

/* rtl/core/convex_hull_graham_scan.sv */
// ----------------------------------------------------------------------------
// convex_hull_graham_scan
// convex hull of a point set by graham scan, with the farthest hull pair
// ----------------------------------------------------------------------------
// usage:
//   points enter on the s_axis channel, one item per point, tlast on the final
//   point of a set. up to 32 points are stored; further points are dropped.
//   while a set is computed and its hull is sent, s_axis_tready stays low.
//   hull vertices leave on the m_axis channel in scan order, tlast on the last
//   one, which also carries the farthest vertex pair and its squared distance.
// sequence, for n points and h hull vertices:
//   pivot search over all n points; insertion sort with up to n*n/2
//   compares; scan with turn tests and a stack read per pop; pair search
//   over h*(h-1)/2 pairs; then the output items, each one loaded only after
//   the receiver has taken the one before. the shared three-stage multiply
//   unit serves every compare, turn test and pair; one memory read port per
//   store sets the sequencing.
// reset: synchronous, active low; the point store is emptied and the block
//   waits for a new set. a stalled receiver holds the current output item.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [chg_pkg::IN_W-1:0]      s_axis_tdata,  // pt_x, pt_y
    input  logic                          s_axis_tlast,  // set_end
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hull_x, hull_y, far_a_x, far_a_y, far_b_x, far_b_y, far_dist_sq, zero pad
    output logic [chg_pkg::OUT_W-1:0]     m_axis_tdata,
    output logic                          m_axis_tlast   // hull_end
);

    chg_pkg::t_op  w_op;
    chg_pkg::t_sts w_sts;

    // sequencer
    chg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_op    (w_op)
    );

    // storage and arithmetic
    chg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .o_sts         (w_sts),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* rtl/core/chg_chk.sv */
// ----------------------------------------------------------------------------
// chg_chk
// port-level checks of the convex hull block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chg_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [chg_pkg::IN_W-1:0]      s_axis_tdata,
    input logic                          s_axis_tlast,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [chg_pkg::OUT_W-1:0]     m_axis_tdata,
    input logic                          m_axis_tlast
);

    logic                                      w_stall;
    logic [chg_pkg::OUT_W-chg_pkg::IN_W-1:0]   w_pair;

    // output item waiting, and the bits above the vertex
    assign w_stall = m_axis_tvalid && !m_axis_tready;
    assign w_pair  = m_axis_tdata[chg_pkg::OUT_W-1:chg_pkg::IN_W];

    // a stalled output item stays
    `CHK_ASSERT(a_out_hold, w_stall |=> m_axis_tvalid && $stable(m_axis_tdata))

    // no input taken while a hull is being sent
    `CHK_NEVER(a_no_overlap, s_axis_tready && m_axis_tvalid)

    // after the last vertex the output goes quiet
    `CHK_ASSERT(a_end_quiet, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)

    // pair fields are zero on every vertex but the last
    `CHK_ASSERT(a_pair_zero, m_axis_tvalid && !m_axis_tlast |-> w_pair == '0)

endmodule

bind convex_hull_graham_scan chg_chk u_chg_chk (.*);
